FILE: design/sacl_pkg.sv
// Shared types and constants for the set-associative LRU cache model core.
// No dependencies.
package sacl_pkg;

  localparam int MaxSetBitsDef = 8;
  localparam int MaxWaysDef    = 8;
  localparam int TagW          = 63;
  localparam int AddrW         = 64;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_STORE  = 2'd1;
  localparam logic [1:0] OP_MODIFY = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  localparam logic [1:0] OUT_HIT   = 2'd0;
  localparam logic [1:0] OUT_MISS  = 2'd1;
  localparam logic [1:0] OUT_EVICT = 2'd2;

  localparam logic [1:0] REG_SET_BITS   = 2'd0;
  localparam logic [1:0] REG_BLOCK_BITS = 2'd1;
  localparam logic [1:0] REG_WAYS       = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr;       // write a cleared row at the sweep address
    logic load_req;  // capture a new request
    logic rd_set;    // issue a set read
    logic update;    // resolve the read set and write it back
    logic last;      // the update is the final lookup of the request
  } sacl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;  // the sweep address is the last set
    logic out_busy;  // result register still full
  } sacl_sts_t;

endpackage

FILE: design/sacl_ctrl.sv
// Controller state machine for the cache model core.
// Depends on sacl_pkg.
module sacl_ctrl import sacl_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [1:0] op,
  input  sacl_sts_t  sts,
  output sacl_cmd_t  cmd
);

  typedef enum logic [4:0] {
    ST_CLR  = 5'b00001,
    ST_IDLE = 5'b00010,
    ST_RD   = 5'b00100,
    ST_UPD  = 5'b01000,
    ST_UPD2 = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   modify_r, modify_nxt;

  always_comb begin
    state_nxt  = state_r;
    modify_nxt = modify_r;
    cmd        = '0;
    in_tready  = 1'b0;
    case (state_r)
      ST_CLR: begin
        // Sweep every set once after reset, one row per cycle.
        cmd.clr = 1'b1;
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid && op != OP_NONE) begin
          cmd.load_req = 1'b1;
          modify_nxt   = (op == OP_MODIFY);
          state_nxt    = ST_RD;
        end
      end
      ST_RD: begin
        cmd.rd_set = 1'b1;
        state_nxt  = ST_UPD;
      end
      ST_UPD: begin
        if (!sts.out_busy) begin
          cmd.update = 1'b1;
          cmd.last   = !modify_r;
          state_nxt  = modify_r ? ST_UPD2 : ST_IDLE;
        end
      end
      ST_UPD2: begin
        // The written set must be read again for the second lookup.
        modify_nxt = 1'b0;
        cmd.rd_set = 1'b1;
        state_nxt  = ST_UPD;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLR;
      modify_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      modify_r <= modify_nxt;
    end
  end

endmodule

FILE: design/sacl_dp.sv
// Datapath of the cache model core: set memory, tag compare, LRU update,
// counters and result register. Depends on sacl_pkg.
module sacl_dp import sacl_pkg::*; #(
  parameter int MAX_SET_BITS = MaxSetBitsDef,
  parameter int MAX_WAYS     = MaxWaysDef
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [AddrW-1:0] addr_in,
  input  logic [3:0]       set_bits,
  input  logic [5:0]       block_bits,
  input  logic [3:0]       ways,
  input  sacl_cmd_t        cmd,
  output sacl_sts_t        sts,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [1:0]       out_outcome,
  output logic [31:0]      hit_total,
  output logic [31:0]      miss_total,
  output logic [31:0]      evict_total,
  output logic             out_last
);

  localparam int NSets   = 1 << MAX_SET_BITS;
  localparam int RankW   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WayW    = $clog2(MAX_WAYS + 1);
  localparam logic [RankW-1:0] RankMax = RankW'(MAX_WAYS - 1);
  localparam int WayRowW = TagW + RankW + 1;
  localparam int RowW    = MAX_WAYS * WayRowW;
  localparam int SbW     = $clog2(MAX_SET_BITS + 1);

  // Memory row: tag, rank and valid bit of every way of one set.
  logic [RowW-1:0] mem [NSets];
  logic [RowW-1:0] row_r;
  logic [MAX_SET_BITS-1:0] clr_r;

  logic [TagW-1:0]         tag_r;
  logic [MAX_SET_BITS-1:0] set_r;
  logic [WayW-1:0]         n_r;

  logic [31:0] hit_r, miss_r, evict_r;
  logic        ov_r, olast_r;
  logic [1:0]  oc_r;

  // Address split, computed at request capture.
  logic [SbW-1:0]         sb;
  logic [6:0]             sh;
  logic [AddrW-1:0]       shb, shs;
  logic [TagW-1:0]        tag_c;
  logic [MAX_SET_BITS-1:0] set_c;
  logic [WayW-1:0]        n_c;

  always_comb begin
    sb    = ({1'b0, set_bits} > 5'(MAX_SET_BITS)) ? SbW'(MAX_SET_BITS) : SbW'(set_bits);
    sh    = 7'(sb) + 7'(block_bits);
    shb   = addr_in >> block_bits;
    shs   = addr_in >> sh;
    tag_c = (sh >= 7'd64) ? '0 : shs[TagW-1:0];
    set_c = shb[MAX_SET_BITS-1:0] &
            MAX_SET_BITS'((({{(MAX_SET_BITS){1'b0}}, 1'b1}) << sb) - 1'b1);
    if (ways == 4'd0) n_c = WayW'(1);
    else if ({2'b0, ways} > 6'(MAX_WAYS)) n_c = WayW'(MAX_WAYS);
    else n_c = WayW'(ways);
  end

  // Lookup and update over the registered row.
  logic [TagW-1:0]  tg  [MAX_WAYS];
  logic [RankW-1:0] rk  [MAX_WAYS];
  logic [RankW-1:0] nrk [MAX_WAYS];
  logic [MAX_WAYS-1:0] use_w, hitv, vrow, nvalid;
  logic             hit, freef;
  logic [RankW-1:0] hw, fw, ew, sel, lim, best;
  logic [1:0]       outc;
  logic [RowW-1:0]  nrow;

  always_comb begin
    hit = 1'b0; freef = 1'b0; hw = '0; fw = '0; ew = '0; best = '0;
    for (int i = 0; i < MAX_WAYS; i++) begin
      tg[i]    = row_r[i*WayRowW +: TagW];
      rk[i]    = row_r[i*WayRowW+TagW +: RankW];
      vrow[i]  = row_r[i*WayRowW+TagW+RankW];
      use_w[i] = (WayW'(i) < n_r);
      hitv[i]  = use_w[i] && vrow[i] && (tg[i] == tag_r);
    end
    for (int i = MAX_WAYS-1; i >= 0; i--) begin
      if (hitv[i]) begin hit = 1'b1; hw = RankW'(i); end
      if (use_w[i] && !vrow[i]) begin freef = 1'b1; fw = RankW'(i); end
    end
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (use_w[i] && rk[i] > best) begin best = rk[i]; ew = RankW'(i); end
    end
    if (hit) begin
      sel = hw; lim = rk[hw]; outc = OUT_HIT;
    end else if (freef) begin
      sel = fw; lim = RankMax; outc = OUT_MISS;
    end else begin
      sel = ew; lim = RankMax; outc = OUT_EVICT;
    end
    nvalid = vrow;
    nvalid[sel] = 1'b1;
    for (int i = 0; i < MAX_WAYS; i++) begin
      nrk[i] = rk[i];
      if (use_w[i] && RankW'(i) != sel && vrow[i] &&
          (hit ? (rk[i] < lim) : 1'b1) && rk[i] < RankMax)
        nrk[i] = rk[i] + 1'b1;
      if (RankW'(i) == sel) nrk[i] = '0;
      nrow[i*WayRowW +: TagW] = (RankW'(i) == sel) ? tag_r : tg[i];
      nrow[i*WayRowW+TagW +: RankW] = nrk[i];
      nrow[i*WayRowW+TagW+RankW] = nvalid[i];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      tag_r  <= tag_c;
      set_r  <= set_c;
      n_r    <= n_c;
    end
    if (cmd.rd_set) row_r <= mem[set_r];
    if (cmd.clr) mem[clr_r] <= '0;
    else if (cmd.update) mem[set_r] <= nrow;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
      hit_r <= '0; miss_r <= '0; evict_r <= '0;
      ov_r <= 1'b0; olast_r <= 1'b0; oc_r <= OUT_HIT;
    end else begin
      if (cmd.clr) clr_r <= clr_r + 1'b1;
      if (cmd.update) begin
        if (outc == OUT_HIT) hit_r <= hit_r + 32'd1;
        else miss_r <= miss_r + 32'd1;
        if (outc == OUT_EVICT) evict_r <= evict_r + 32'd1;
        ov_r <= 1'b1; oc_r <= outc; olast_r <= cmd.last;
      end else if (out_tready) begin
        ov_r <= 1'b0;
      end
    end
  end

  assign sts.clr_last = &clr_r;
  assign sts.out_busy = ov_r && !out_tready;
  assign out_tvalid   = ov_r;
  assign out_outcome  = oc_r;
  assign hit_total    = hit_r;
  assign miss_total   = miss_r;
  assign evict_total  = evict_r;
  assign out_last     = olast_r;

endmodule

FILE: design/set_assoc_cache_lru_sim_core.sv
// Top level of the set-associative LRU cache model core.
// Depends on sacl_pkg, sacl_ctrl and sacl_dp.
//
// Each request on the in_ channel is a load, store or modify to a 64-bit
// byte address. A load or store gives one result on the out_ channel and a
// modify gives two, the second marked with out_tlast; the first of a pair
// has out_tlast low. The unused operation code is taken and yields nothing.
// Each result carries the outcome (hit, miss, miss with eviction) and the
// running hit, miss and eviction totals after that lookup.
// A lookup is a read-modify-write of one set row in the set memory: the
// read step registers the row, then the update step resolves the tag
// compare and LRU update, writes the row back and loads the result
// register. The second lookup of a modify rereads the written row. One
// request is in work at a time, so a new request is taken only once the
// controller is idle again after the last result has been loaded.
// If the receiver stalls, the result waits in the output register and the
// update step waits until the register is free.
// Reset clears the controller and the counters; the controller then sweeps
// the set memory, one set per cycle, clearing valid bits, ranks and tags
// with in_tready held low.
// Configuration is taken from the cfg_ port whenever cfg_we is high and
// should only change while idle.
module set_assoc_cache_lru_sim_core import sacl_pkg::*; #(
  parameter int MAX_SET_BITS = MaxSetBitsDef,
  parameter int MAX_WAYS     = MaxWaysDef
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [71:0]  in_tdata,  // [1:0] operation, [65:2] address
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [5:0]   cfg_data,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata, // [1:0] outcome, [33:2] hit_total,
                                  // [65:34] miss_total, [97:66] evict_total
  output logic         out_tlast
);

  logic [3:0] set_bits_r;
  logic [5:0] block_bits_r;
  logic [3:0] ways_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r   <= 4'd1;
      block_bits_r <= 6'd4;
      ways_r       <= 4'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SET_BITS:   set_bits_r   <= cfg_data[3:0];
        REG_BLOCK_BITS: block_bits_r <= cfg_data;
        REG_WAYS:       ways_r       <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  sacl_cmd_t   cmd;
  sacl_sts_t   sts;
  logic [1:0]  oc;
  logic [31:0] ht, mt, et;

  sacl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .op        (in_tdata[1:0]),
    .sts       (sts),
    .cmd       (cmd)
  );

  sacl_dp #(.MAX_SET_BITS(MAX_SET_BITS), .MAX_WAYS(MAX_WAYS)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .addr_in     (in_tdata[65:2]),
    .set_bits    (set_bits_r),
    .block_bits  (block_bits_r),
    .ways        (ways_r),
    .cmd         (cmd),
    .sts         (sts),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_outcome (oc),
    .hit_total   (ht),
    .miss_total  (mt),
    .evict_total (et),
    .out_last    (out_tlast)
  );

  assign out_tdata = {6'd0, et, mt, ht, oc};

  // The hit and miss totals together move by exactly one per result.
  a_one_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && $past(rst_n)) |=>
      (out_tdata[65:2] == $past(out_tdata[65:2])) || !out_tvalid ||
      (out_tdata[33:2] + out_tdata[65:34] ==
       $past(out_tdata[33:2] + out_tdata[65:34]) + 32'd1))
    else $error("lookup totals moved by other than one");

  // Every update step loads the result register.
  a_evict: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.update && $past(rst_n)) |=> out_tvalid)
    else $error("update did not load the result register");

  // No request is taken while a lookup is in work.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_req |=> !in_tready)
    else $error("request taken during a lookup");

endmodule
